[design/motion_safety_interlock_macros.svh]
// Assertion helpers for the motion safety interlock.
`ifndef MOTION_SAFETY_INTERLOCK_MACROS_SVH
`define MOTION_SAFETY_INTERLOCK_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MSI_ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("interlock check failed");

// Next-cycle implication, checked out of reset.
`define MSI_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("interlock sequencing check failed");

`endif

[design/msi_pkg.sv]
package msi_pkg;

	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned LEVEL_W = 16;
	localparam int unsigned COUNT_W = 8;
	localparam int unsigned TIME_W = 32;

	localparam logic [COUNT_W-1:0] RUN_MAX = 8'd255;

	typedef enum logic [2:0] {
		CAUSE_NONE     = 3'd0,
		CAUSE_STALE    = 3'd1,
		CAUSE_IMU      = 3'd2,
		CAUSE_RANGE    = 3'd3,
		CAUSE_OBSTACLE = 3'd4,
		CAUSE_VIBE     = 3'd5
	} cause_t;

	typedef enum logic [2:0] {
		EVT_NONE          = 3'd0,
		EVT_VIBE_FAULT    = 3'd1,
		EVT_STOP          = 3'd2,
		EVT_BLOCK_CHANGED = 3'd3,
		EVT_BLOCK_CLEARED = 3'd4
	} event_t;

	typedef enum logic [2:0] {
		REG_VIBE_ENTER_LEVEL   = 3'd0,
		REG_VIBE_CLEAR_LEVEL   = 3'd1,
		REG_ENTER_SAMPLE_COUNT = 3'd2,
		REG_CLEAR_SAMPLE_COUNT = 3'd3,
		REG_STALE_LIMIT_MS     = 3'd4,
		REG_OBSTACLE_STOP_DIST = 3'd5
	} reg_index_t;

	localparam logic [LEVEL_W-1:0] VIBE_ENTER_LEVEL_RST   = 16'd512;
	localparam logic [LEVEL_W-1:0] VIBE_CLEAR_LEVEL_RST   = 16'd256;
	localparam logic [COUNT_W-1:0] ENTER_SAMPLE_COUNT_RST = 8'd3;
	localparam logic [COUNT_W-1:0] CLEAR_SAMPLE_COUNT_RST = 8'd10;
	localparam logic [LEVEL_W-1:0] STALE_LIMIT_MS_RST     = 16'd500;
	localparam logic [LEVEL_W-1:0] OBSTACLE_STOP_DIST_RST = 16'd150;

	// Result flags that travel with one item from the decision logic to the output register.
	typedef struct packed {
		logic   fault_cleared_evt;
		event_t event_kind;
		logic   stop_sequence;
		logic   emergency_stop;
		logic   request_safe;
		logic   request_fault;
	} result_flags_t;

	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
		return (v == RUN_MAX) ? v : v + COUNT_W'(1);
	endfunction

endpackage

[design/motion_safety_interlock.sv]
// The result passes through the input register, then the result register; the result handshake
// waits while a stalled output holds the result register.
// Throughput: one item per cycle while the output is not stalled; the decision logic is a single pass
// of compares and adds between the input register and the result register, so nothing iterates.
// Reset (arst_n low, asynchronous): configuration registers return to their documented defaults, all run
// counters, state flags, cause and event time clear, and both pipeline stages empty; result flags are not reset.
module motion_safety_interlock (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [msi_pkg::ADDR_W-1:0]   paddr,
	input  logic [msi_pkg::DATA_W-1:0]   pwdata,
	output logic [msi_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	// input channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [msi_pkg::TIME_W-1:0]   now_ms,
	input  logic [msi_pkg::TIME_W-1:0]   last_update_ms,
	input  logic                         link_up,
	input  logic                         imu_good,
	input  logic                         range_good,
	input  logic [msi_pkg::LEVEL_W-1:0]  vibe_level,
	input  logic [msi_pkg::LEVEL_W-1:0]  obstacle_dist,
	input  logic                         sys_in_fault,
	input  logic                         sys_armed,
	input  logic                         motor_enabled,
	// output channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         motion_blocked,
	output logic [2:0]                   block_cause,
	output logic                         fault_latched,
	output logic                         fault_cleared_evt,
	output logic [2:0]                   event_kind,
	output logic                         stop_sequence,
	output logic                         emergency_stop,
	output logic                         request_safe,
	output logic                         request_fault,
	output logic [msi_pkg::TIME_W-1:0]   last_event_ms
);
	import msi_pkg::*;

	// configuration registers
	logic [LEVEL_W-1:0] vibe_enter_level_q;
	logic [LEVEL_W-1:0] vibe_clear_level_q;
	logic [COUNT_W-1:0] enter_sample_count_q;
	logic [COUNT_W-1:0] clear_sample_count_q;
	logic [LEVEL_W-1:0] stale_limit_ms_q;
	logic [LEVEL_W-1:0] obstacle_stop_dist_q;

	reg_index_t reg_idx;
	logic       cfg_wr;

	// input stage
	logic               in_valid_s1;
	logic [TIME_W-1:0]  now_ms_s1;
	logic [TIME_W-1:0]  last_update_ms_s1;
	logic               link_up_s1;
	logic               imu_good_s1;
	logic               range_good_s1;
	logic [LEVEL_W-1:0] vibe_level_s1;
	logic [LEVEL_W-1:0] obstacle_dist_s1;
	logic               sys_in_fault_s1;
	logic               sys_armed_s1;
	logic               motor_enabled_s1;

	// interlock state
	logic               blocked_q;
	cause_t             cause_q;
	logic               fault_latch_q;
	logic               vibe_active_q;
	logic [COUNT_W-1:0] high_run_q;
	logic [COUNT_W-1:0] low_run_q;
	logic [TIME_W-1:0]  event_time_q;

	// result stage
	logic          out_valid_s2;
	result_flags_t flags_s2;

	// next-state logic
	logic               s2_load;
	logic               hi_sample;
	logic               lo_sample;
	logic [COUNT_W-1:0] high_run_a;
	logic [COUNT_W-1:0] low_run_a;
	logic [COUNT_W-1:0] high_run_d;
	logic [COUNT_W-1:0] low_run_d;
	logic               vibe_active_d;
	logic               latch_kept;
	logic               latched_in_fault;
	logic [TIME_W-1:0]  age_ms;
	logic               stale;
	cause_t             next_cause;
	logic               blocked_d;
	cause_t             cause_d;
	logic               fault_latch_d;
	logic [TIME_W-1:0]  event_time_d;
	result_flags_t      flags_d;

	// ------------------------------------------------------------------ config port
	assign pready  = 1'b1;
	assign reg_idx = reg_index_t'(paddr[ADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		case (reg_idx)
			REG_VIBE_ENTER_LEVEL:   prdata = DATA_W'(vibe_enter_level_q);
			REG_VIBE_CLEAR_LEVEL:   prdata = DATA_W'(vibe_clear_level_q);
			REG_ENTER_SAMPLE_COUNT: prdata = DATA_W'(enter_sample_count_q);
			REG_CLEAR_SAMPLE_COUNT: prdata = DATA_W'(clear_sample_count_q);
			REG_STALE_LIMIT_MS:     prdata = DATA_W'(stale_limit_ms_q);
			REG_OBSTACLE_STOP_DIST: prdata = DATA_W'(obstacle_stop_dist_q);
			default:                prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vibe_enter_level_q   <= VIBE_ENTER_LEVEL_RST;
			vibe_clear_level_q   <= VIBE_CLEAR_LEVEL_RST;
			enter_sample_count_q <= ENTER_SAMPLE_COUNT_RST;
			clear_sample_count_q <= CLEAR_SAMPLE_COUNT_RST;
			stale_limit_ms_q     <= STALE_LIMIT_MS_RST;
			obstacle_stop_dist_q <= OBSTACLE_STOP_DIST_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_VIBE_ENTER_LEVEL:   vibe_enter_level_q   <= pwdata[LEVEL_W-1:0];
				REG_VIBE_CLEAR_LEVEL:   vibe_clear_level_q   <= pwdata[LEVEL_W-1:0];
				REG_ENTER_SAMPLE_COUNT: enter_sample_count_q <= pwdata[COUNT_W-1:0];
				REG_CLEAR_SAMPLE_COUNT: clear_sample_count_q <= pwdata[COUNT_W-1:0];
				REG_STALE_LIMIT_MS:     stale_limit_ms_q     <= pwdata[LEVEL_W-1:0];
				REG_OBSTACLE_STOP_DIST: obstacle_stop_dist_q <= pwdata[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------ handshake
	assign s2_load  = in_valid_s1 && (!out_valid_s2 || !out_stall);
	assign in_stall = in_valid_s1 && !s2_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			now_ms_s1         <= now_ms;
			last_update_ms_s1 <= last_update_ms;
			link_up_s1        <= link_up;
			imu_good_s1       <= imu_good;
			range_good_s1     <= range_good;
			vibe_level_s1     <= vibe_level;
			obstacle_dist_s1  <= obstacle_dist;
			sys_in_fault_s1   <= sys_in_fault;
			sys_armed_s1      <= sys_armed;
			motor_enabled_s1  <= motor_enabled;
		end
	end

	// ------------------------------------------------------------------ vibration hysteresis
	assign hi_sample = vibe_level_s1 >= vibe_enter_level_q;
	assign lo_sample = vibe_level_s1 <= vibe_clear_level_q;

	always_comb begin
		high_run_a = hi_sample ? sat_inc(high_run_q) : '0;
		low_run_a  = (!hi_sample && lo_sample) ? sat_inc(low_run_q) : '0;

		high_run_d    = high_run_a;
		low_run_d     = low_run_a;
		vibe_active_d = vibe_active_q;
		if (!vibe_active_q && high_run_a >= enter_sample_count_q) begin
			vibe_active_d = 1'b1;
			low_run_d     = '0;
		end else if (vibe_active_q && low_run_a >= clear_sample_count_q) begin
			vibe_active_d = 1'b0;
			high_run_d    = '0;
		end
	end

	// ------------------------------------------------------------------ cause selection
	assign age_ms = now_ms_s1 - last_update_ms_s1;
	assign stale  = !link_up_s1 || (last_update_ms_s1 == '0) ||
		(age_ms > TIME_W'(stale_limit_ms_q));

	always_comb begin
		if (stale)
			next_cause = CAUSE_STALE;
		else if (!imu_good_s1)
			next_cause = CAUSE_IMU;
		else if (!range_good_s1)
			next_cause = CAUSE_RANGE;
		else if (vibe_active_d)
			next_cause = CAUSE_VIBE;
		else if (obstacle_dist_s1 != '0 && obstacle_dist_s1 < obstacle_stop_dist_q)
			next_cause = CAUSE_OBSTACLE;
		else
			next_cause = CAUSE_NONE;
	end

	// ------------------------------------------------------------------ block and event decision
	assign latched_in_fault = fault_latch_q && sys_in_fault_s1;
	// drop the latch once the system has left FAULT
	assign latch_kept = latched_in_fault;

	always_comb begin
		flags_d                   = '0;
		flags_d.event_kind        = EVT_NONE;
		flags_d.fault_cleared_evt = fault_latch_q && !sys_in_fault_s1;
		blocked_d                 = blocked_q;
		cause_d                   = cause_q;
		fault_latch_d             = latch_kept;
		event_time_d              = event_time_q;

		case (next_cause)
			CAUSE_VIBE: begin
				if (!latched_in_fault && cause_q != CAUSE_VIBE) begin
					flags_d.stop_sequence  = 1'b1;
					flags_d.emergency_stop = 1'b1;
					flags_d.request_fault  = 1'b1;
					flags_d.event_kind     = EVT_VIBE_FAULT;
					fault_latch_d          = 1'b1;
				end
				blocked_d    = 1'b1;
				cause_d      = CAUSE_VIBE;
				event_time_d = now_ms_s1;
			end
			CAUSE_NONE: begin
				// stay quiet when leaving a vibration block whose fault is still latched
				if (blocked_q && !(cause_q == CAUSE_VIBE && latch_kept))
					flags_d.event_kind = EVT_BLOCK_CLEARED;
				blocked_d = 1'b0;
				cause_d   = CAUSE_NONE;
			end
			default: begin
				if (cause_q != next_cause) begin
					if (!blocked_q) begin
						flags_d.stop_sequence  = 1'b1;
						flags_d.emergency_stop = sys_armed_s1 || motor_enabled_s1;
						flags_d.request_safe   = sys_armed_s1;
						flags_d.event_kind     = EVT_STOP;
					end else begin
						flags_d.event_kind = EVT_BLOCK_CHANGED;
					end
					event_time_d = now_ms_s1;
				end
				blocked_d = 1'b1;
				cause_d   = next_cause;
			end
		endcase
	end

	// ------------------------------------------------------------------ state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocked_q     <= 1'b0;
			cause_q       <= CAUSE_NONE;
			fault_latch_q <= 1'b0;
			vibe_active_q <= 1'b0;
			high_run_q    <= '0;
			low_run_q     <= '0;
			event_time_q  <= '0;
		end else if (s2_load) begin
			blocked_q     <= blocked_d;
			cause_q       <= cause_d;
			fault_latch_q <= fault_latch_d;
			vibe_active_q <= vibe_active_d;
			high_run_q    <= high_run_d;
			low_run_q     <= low_run_d;
			event_time_q  <= event_time_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (s2_load) begin
			out_valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load)
			flags_s2 <= flags_d;
	end

	// state only moves when a new result loads, so it doubles as the held payload
	assign out_valid         = out_valid_s2;
	assign motion_blocked    = blocked_q;
	assign block_cause       = cause_q;
	assign fault_latched     = fault_latch_q;
	assign last_event_ms     = event_time_q;
	assign fault_cleared_evt = flags_s2.fault_cleared_evt;
	assign event_kind        = flags_s2.event_kind;
	assign stop_sequence     = flags_s2.stop_sequence;
	assign emergency_stop    = flags_s2.emergency_stop;
	assign request_safe      = flags_s2.request_safe;
	assign request_fault     = flags_s2.request_fault;

	// ------------------------------------------------------------------ assertions
`include "motion_safety_interlock_macros.svh"

	`MSI_ASSERT_IMPLIES(a_fault_req_consistent, clk, arst_n, out_valid && request_fault, fault_latched && motion_blocked && block_cause == CAUSE_VIBE && event_kind == EVT_VIBE_FAULT)
	`MSI_ASSERT_IMPLIES(a_unblocked_no_cause, clk, arst_n, !motion_blocked, block_cause == CAUSE_NONE)
	`MSI_ASSERT_IMPLIES(a_safe_needs_estop, clk, arst_n, out_valid && request_safe, emergency_stop && stop_sequence && event_kind == EVT_STOP)
	`MSI_ASSERT_NEXT(a_state_holds_when_stalled, clk, arst_n, out_valid && out_stall, $stable(blocked_q) && $stable(cause_q) && $stable(event_time_q))

endmodule
